>>> src/tnet_pkg.sv
// ----------------------------------------------------------------------------
// tnet_pkg
// Shared types and constants of the timed note event table.
// ----------------------------------------------------------------------------
package tnet_pkg;

	localparam int TIME_W   = 64;
	localparam int OFFSET_W = 16;
	localparam int LIMIT_W  = 7;

	localparam logic [LIMIT_W-1:0] MAX_OUT = 7'd64;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_COLLECT = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] track;
		logic [6:0] note;
		logic [6:0] velocity;
	} info_t;

	typedef struct packed {
		logic clr;
		logic eval;
	} scan_ctl_t;

endpackage

>>> src/tnet_mem.sv
// ----------------------------------------------------------------------------
// tnet_mem
// Event store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tnet_mem import tnet_pkg::*; #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [TIME_W-1:0] wtime,
	input  info_t             winfo,
	input  logic [ADDR_W-1:0] raddr,
	output logic [TIME_W-1:0] rtime,
	output info_t             rinfo
);

	logic [TIME_W-1:0] time_mem [DEPTH];
	info_t             info_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
			info_mem[waddr] <= winfo;
		end
		rtime <= time_mem[raddr];
		rinfo <= info_mem[raddr];
	end

endmodule

>>> src/tnet_scan.sv
// ----------------------------------------------------------------------------
// tnet_scan
// Shared window check and best-event compare, one stored entry per cycle while eval is set.
// ----------------------------------------------------------------------------
module tnet_scan import tnet_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_ctl_t           ctl,
	input  logic [TIME_W-1:0]   rd_time,
	input  info_t               rd_info,
	input  logic [IDX_W-1:0]    rd_idx,
	input  logic                rd_taken,
	input  logic [TIME_W-1:0]   blk_start,
	input  logic [OFFSET_W-1:0] blk_frames,
	output logic                have,
	output logic [IDX_W-1:0]    sel_idx,
	output info_t               sel_info,
	output logic [OFFSET_W-1:0] sel_offset
);

	logic [TIME_W:0]   diff;
	logic              in_win;
	logic              better;
	logic              have_q;
	logic [TIME_W-1:0] best_time_q;

	always_comb begin
		diff   = {1'b0, rd_time} - {1'b0, blk_start};
		in_win = !diff[TIME_W] && (diff[TIME_W-1:OFFSET_W] == '0)
			&& (diff[OFFSET_W-1:0] < blk_frames);
		better = !have_q || (rd_time < best_time_q)
			|| ((rd_time == best_time_q) && rd_info.kind && !sel_info.kind);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clr) begin
			have_q <= 1'b0;
		end else if (ctl.eval && !rd_taken && in_win && better) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.eval && !rd_taken && in_win && better) begin
			best_time_q <= rd_time;
			sel_idx     <= rd_idx;
			sel_info    <= rd_info;
			sel_offset  <= diff[OFFSET_W-1:0];
		end
	end

	assign have = have_q;

endmodule

>>> src/timed_note_event_table.sv
// ----------------------------------------------------------------------------
// timed_note_event_table
// Ordered table of pending note events with push, block collect and clear.
// ----------------------------------------------------------------------------
// Push and clear are taken while idle and busy stays low. A collect that
// gives n events keeps busy high until it ends. Each pass of the shared compare
// unit runs over every stored entry, through the single read port of the event
// store. The pass that finds nothing ends the search, and a final pass packs the
// remaining entries down in order. When n reaches the limit, a flush state
// replaces the empty pass. When nothing falls in the block, the collect ends
// after one pass with no pack. An empty collect (no entries or a limit of
// zero) leaves busy low and answers on the next cycle. Results appear on a
// one-cycle strobe, valid, and the receiver cannot stall them; last marks the
// final result of each collect.
module timed_note_event_table import tnet_pkg::*; #(
	parameter int EVENT_CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic [TIME_W-1:0]   event_time,
	input  logic                event_kind,
	input  logic [7:0]          track_id,
	input  logic [6:0]          note_number,
	input  logic [6:0]          note_velocity,
	input  logic [LIMIT_W-1:0]  limit_events,
	input  logic [OFFSET_W-1:0] frame_count,
	input  logic [TIME_W-1:0]   block_start,
	output logic                valid,
	output logic                found,
	output logic                out_kind,
	output logic [7:0]          out_track,
	output logic [6:0]          out_note,
	output logic [6:0]          out_velocity,
	output logic [OFFSET_W-1:0] block_offset,
	output logic                last
);

	localparam int IW = (EVENT_CAPACITY > 1) ? $clog2(EVENT_CAPACITY) : 1;
	localparam int CW = $clog2(EVENT_CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(EVENT_CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_PICK,
		S_FLUSH,
		S_PACK,
		S_PDRAIN
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           w_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           idx_s1;
	logic                    vld_s1;
	logic [EVENT_CAPACITY-1:0] taken_q;
	logic [TIME_W-1:0]       start_q;
	logic [OFFSET_W-1:0]     frames_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic [LIMIT_W-1:0]      n_q;
	logic                    pend_v_q;
	info_t                   pend_info_q;
	logic [OFFSET_W-1:0]     pend_off_q;

	logic                    valid_q;
	logic                    found_q;
	info_t                   res_info_q;
	logic [OFFSET_W-1:0]     res_off_q;
	logic                    last_q;

	logic                    push_acc;
	logic                    push_we;
	logic                    clear_acc;
	logic                    coll_acc;
	logic                    pack_keep;
	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic [TIME_W-1:0]       mem_wtime;
	info_t                   mem_winfo;
	info_t                   push_info;
	logic [TIME_W-1:0]       rd_time;
	info_t                   rd_info;
	logic [LIMIT_W-1:0]      lim_c;
	logic                    idx_end;
	scan_ctl_t               scan_ctl;
	logic                    sc_have;
	logic [IW-1:0]           sc_idx;
	info_t                   sc_info;
	logic [OFFSET_W-1:0]     sc_off;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		push_acc  = start && !busy && (op == OP_PUSH);
		push_we   = push_acc && (count_q < CAP_C);
		clear_acc = start && !busy && (op == OP_CLEAR);
		coll_acc  = start && !busy && (op == OP_COLLECT);
		lim_c     = (limit_events > MAX_OUT) ? MAX_OUT : limit_events;
		idx_end   = (idx_q == IW'(count_q - 1'b1));
		pack_keep = ((state_q == S_PACK) || (state_q == S_PDRAIN)) && vld_s1
			&& !taken_q[idx_s1];
		push_info.kind     = event_kind;
		push_info.track    = track_id;
		push_info.note     = note_number;
		push_info.velocity = note_velocity;
		mem_we    = push_we || pack_keep;
		mem_waddr = pack_keep ? w_q[IW-1:0] : count_q[IW-1:0];
		mem_wtime = pack_keep ? rd_time : event_time;
		mem_winfo = pack_keep ? rd_info : push_info;
		scan_ctl.clr  = coll_acc || (state_q == S_PICK);
		scan_ctl.eval = vld_s1 && ((state_q == S_SCAN) || (state_q == S_WAIT));
	end

	tnet_mem #(
		.DEPTH  (EVENT_CAPACITY),
		.ADDR_W (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wtime (mem_wtime),
		.winfo (mem_winfo),
		.raddr (idx_q),
		.rtime (rd_time),
		.rinfo (rd_info)
	);

	tnet_scan #(
		.IDX_W (IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.rd_time    (rd_time),
		.rd_info    (rd_info),
		.rd_idx     (idx_s1),
		.rd_taken   (taken_q[idx_s1]),
		.blk_start  (start_q),
		.blk_frames (frames_q),
		.have       (sc_have),
		.sel_idx    (sc_idx),
		.sel_info   (sc_info),
		.sel_offset (sc_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			w_q        <= '0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			taken_q    <= '0;
			n_q        <= '0;
			pend_v_q   <= 1'b0;
			valid_q    <= 1'b0;
			found_q    <= 1'b0;
			last_q     <= 1'b0;
			res_info_q <= '0;
			res_off_q  <= '0;
		end else begin
			valid_q <= 1'b0;
			vld_s1  <= (state_q == S_SCAN) || (state_q == S_PACK);
			case (state_q)
				S_IDLE: begin
					if (push_we) begin
						count_q <= count_q + 1'b1;
					end
					if (clear_acc) begin
						count_q <= '0;
					end
					if (coll_acc) begin
						n_q        <= '0;
						taken_q    <= '0;
						pend_v_q   <= 1'b0;
						idx_q      <= '0;
						res_info_q <= '0;
						res_off_q  <= '0;
						if ((lim_c == '0) || (count_q == '0)) begin
							valid_q <= 1'b1;
							found_q <= 1'b0;
							last_q  <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_end) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					idx_q      <= '0;
					w_q        <= '0;
					res_info_q <= pend_v_q ? pend_info_q : '0;
					res_off_q  <= pend_v_q ? pend_off_q : '0;
					if (sc_have) begin
						taken_q[sc_idx] <= 1'b1;
						if (pend_v_q) begin
							valid_q <= 1'b1;
							found_q <= 1'b1;
							last_q  <= 1'b0;
						end
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
						state_q  <= ((n_q + 1'b1) == limit_q) ? S_FLUSH : S_SCAN;
					end else begin
						valid_q <= 1'b1;
						found_q <= pend_v_q;
						last_q  <= 1'b1;
						state_q <= pend_v_q ? S_PACK : S_IDLE;
					end
				end
				S_FLUSH: begin
					valid_q    <= 1'b1;
					found_q    <= 1'b1;
					last_q     <= 1'b1;
					res_info_q <= pend_info_q;
					res_off_q  <= pend_off_q;
					state_q    <= S_PACK;
				end
				S_PACK: begin
					idx_q <= idx_q + 1'b1;
					if (pack_keep) begin
						w_q <= w_q + 1'b1;
					end
					if (idx_end) begin
						state_q <= S_PDRAIN;
					end
				end
				S_PDRAIN: begin
					count_q <= pack_keep ? (w_q + 1'b1) : w_q;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (coll_acc) begin
			start_q  <= block_start;
			frames_q <= (frame_count == '0) ? OFFSET_W'(1) : frame_count;
			limit_q  <= lim_c;
		end
		if ((state_q == S_PICK) && sc_have) begin
			pend_info_q <= sc_info;
			pend_off_q  <= sc_off;
		end
	end

	assign valid        = valid_q;
	assign found        = found_q;
	assign out_kind     = res_info_q.kind;
	assign out_track    = res_info_q.track;
	assign out_note     = res_info_q.note;
	assign out_velocity = res_info_q.velocity;
	assign block_offset = res_off_q;
	assign last         = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(push_acc && (count_q == CAP_C)) |=> (count_q == CAP_C))
		else $error("push into full table changed count");

	a_mid_in_collect: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final result outside a collect");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !found) |-> last)
		else $error("empty result not marked last");

endmodule
